FILE: design/tilt_rep_counter_top_macros.svh
// Assertion macros used by the tilt repetition counter back end.
`ifndef TILT_REP_COUNTER_TOP_MACROS_SVH
`define TILT_REP_COUNTER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TRC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TRC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/trc_pkg.sv
// Types, constants and the arctangent table of the tilt repetition counter.
`default_nettype none

package trc_pkg;

   // Field and datapath widths.
   localparam int ANGLE_W      = 12;
   localparam int AXIS_W       = 16;
   localparam int TOTAL_W      = 16;
   localparam int EVENT_W      = 2;
   localparam int CSR_INDEX_W  = 3;
   localparam int XY_W         = 26;
   localparam int ACC_W        = 22;
   localparam int TAB_W        = 18;
   localparam int TAB_IDX_W    = 5;
   localparam int QUEUE_DEPTH  = 2;

   // Angle constants in sixteenths of a degree; ROUND_HALF is in 4096ths of a degree.
   localparam logic [ANGLE_W-1:0] ANGLE_RIGHT    = 12'd1440;
   localparam logic [ANGLE_W-1:0] ANGLE_STRAIGHT = 12'd2880;
   localparam logic [ACC_W-1:0]   ROUND_HALF     = 22'd128;

   // Request codes.
   localparam logic REQ_CLEAR = 1'b1;

   // Result event codes.
   localparam logic [EVENT_W-1:0] EVENT_NONE = 2'd0;
   localparam logic [EVENT_W-1:0] EVENT_GOOD = 2'd1;
   localparam logic [EVENT_W-1:0] EVENT_BAD  = 2'd2;

   // Register indexes and reset values.
   localparam logic [CSR_INDEX_W-1:0] REG_START   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_END     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FULL    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PARTIAL = 3'd3;

   localparam logic [ANGLE_W-1:0] START_RESET   = 12'd240;
   localparam logic [ANGLE_W-1:0] END_RESET     = 12'd160;
   localparam logic [ANGLE_W-1:0] FULL_RESET    = 12'd1200;
   localparam logic [ANGLE_W-1:0] PARTIAL_RESET = 12'd480;

   // How the back end has to treat a queued word.
   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_ZERO_Y = 2'd1,
      KIND_ZERO_Z = 2'd2,
      KIND_ROTATE = 2'd3
   } item_kind_type;

   typedef struct packed {
      item_kind_type     kind;
      logic              z_neg;
      logic [AXIS_W-1:0] mag_y;
      logic [AXIS_W-1:0] mag_z;
   } queue_entry_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] start_th;
      logic [ANGLE_W-1:0] end_th;
      logic [ANGLE_W-1:0] full_th;
      logic [ANGLE_W-1:0] partial_th;
   } thresholds_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_ROTATE = 4'b0010,
      ST_ANGLE  = 4'b0100,
      ST_UPDATE = 4'b1000
   } back_state_type;

   // atan(2^-i) in degrees scaled by 4096, rounded to nearest.
   function automatic logic [TAB_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
      logic [TAB_W-1:0] val;
      unique case (idx)
         5'd0:  val = 18'd184320;
         5'd1:  val = 18'd108810;
         5'd2:  val = 18'd57492;
         5'd3:  val = 18'd29184;
         5'd4:  val = 18'd14649;
         5'd5:  val = 18'd7331;
         5'd6:  val = 18'd3667;
         5'd7:  val = 18'd1833;
         5'd8:  val = 18'd917;
         5'd9:  val = 18'd458;
         5'd10: val = 18'd229;
         5'd11: val = 18'd115;
         5'd12: val = 18'd57;
         5'd13: val = 18'd29;
         5'd14: val = 18'd14;
         5'd15: val = 18'd7;
         5'd16: val = 18'd4;
         5'd17: val = 18'd2;
         5'd18: val = 18'd1;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

FILE: design/trc_channels.sv
// Channel interfaces for requests, results and register writes.
`default_nettype none

interface trc_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [15:0] accel_y;
   logic [15:0] accel_z;

   modport source (output valid, output req_type, output accel_y, output accel_z,
                   input ready);
   modport sink   (input valid, input req_type, input accel_y, input accel_z,
                   output ready);
endinterface

interface trc_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] tilt_angle;
   logic        rep_active;
   logic [1:0]  rep_event;
   logic [15:0] good_total;
   logic [15:0] bad_total;

   modport source (output valid, output tilt_angle, output rep_active, output rep_event,
                   output good_total, output bad_total, input ready);
   modport sink   (input valid, input tilt_angle, input rep_active, input rep_event,
                   input good_total, input bad_total, output ready);
endinterface

interface trc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [11:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/trc_front.sv
// Front end: takes request words, folds the axes to magnitudes and classifies them.
`default_nettype none

module trc_front (
   trc_req_if.sink                 req_ch,
   output logic                    push_valid,
   output trc_pkg::queue_entry_type push_entry,
   input  logic                    push_ready
);
   import trc_pkg::*;

   logic [AXIS_W-1:0] mag_y;
   logic [AXIS_W-1:0] mag_z;

   // Magnitudes; the most negative value folds to 32768, which still fits unsigned.
   assign mag_y = req_ch.accel_y[AXIS_W-1] ? AXIS_W'(-req_ch.accel_y) : req_ch.accel_y;
   assign mag_z = req_ch.accel_z[AXIS_W-1] ? AXIS_W'(-req_ch.accel_z) : req_ch.accel_z;

   // Classification decides which path the back end takes.
   always_comb begin
      push_entry.mag_y = mag_y;
      push_entry.mag_z = mag_z;
      push_entry.z_neg = req_ch.accel_z[AXIS_W-1];
      priority if (req_ch.req_type == REQ_CLEAR) begin
         push_entry.kind = KIND_CLEAR;
      end else if (mag_y == '0) begin
         push_entry.kind = KIND_ZERO_Y;
      end else if (mag_z == '0) begin
         push_entry.kind = KIND_ZERO_Z;
      end else begin
         push_entry.kind = KIND_ROTATE;
      end
   end

   assign push_valid   = req_ch.valid;
   assign req_ch.ready = push_ready;

endmodule

`default_nettype wire

FILE: design/trc_queue.sv
// Short queue of classified words between the front and back ends.
`default_nettype none

module trc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  trc_pkg::queue_entry_type push_entry,
   output logic                     push_ready,
   output logic                     pop_valid,
   output trc_pkg::queue_entry_type pop_entry,
   input  logic                     pop_ready
);
   import trc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   queue_entry_type  slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_fire;
   logic             pop_fire;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset: a slot is read only once it has been written.
   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

FILE: design/trc_back.sv
// Back end: iterative arctangent, repetition state machine and result register.
`default_nettype none

module trc_back #(
   parameter int ANGLE_ITERATIONS = 16,
   parameter int COUNT_BITS       = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  trc_pkg::thresholds_type  thresholds,
   input  logic                     pop_valid,
   input  trc_pkg::queue_entry_type pop_entry,
   output logic                     pop_ready,
   trc_rsp_if.source                rsp_ch
);
   import trc_pkg::*;

`include "tilt_rep_counter_top_macros.svh"

   localparam int ITER_BITS = (ANGLE_ITERATIONS > 1) ? $clog2(ANGLE_ITERATIONS) : 1;
   localparam logic [ITER_BITS-1:0] ITER_LAST = ITER_BITS'(ANGLE_ITERATIONS - 1);
   localparam int BASE_W = ACC_W - 8;

   back_state_type           state_ff, state_in;
   item_kind_type            kind_ff;
   logic                     z_neg_ff;
   logic signed [XY_W-1:0]   x_ff, x_in;
   logic signed [XY_W-1:0]   y_ff, y_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [ITER_BITS-1:0]     iter_ff;
   logic [ANGLE_W-1:0]       angle_ff, angle_in;

   logic                     in_motion_ff, in_motion_in;
   logic [ANGLE_W-1:0]       peak_ff, peak_in;
   logic [COUNT_BITS-1:0]    good_ff, good_in;
   logic [COUNT_BITS-1:0]    bad_ff, bad_in;

   logic                     rsp_valid_ff;
   logic [ANGLE_W-1:0]       tilt_ff;
   logic                     active_ff;
   logic [EVENT_W-1:0]       event_ff, event_in;

   logic                     out_free;
   logic                     commit;
   logic                     pop_fire;
   logic signed [XY_W-1:0]   step_x;
   logic signed [XY_W-1:0]   step_y;
   logic [TAB_W-1:0]         tab_val;
   logic signed [ACC_W-1:0]  tab_ext;
   logic [ACC_W-1:0]         acc_pos;
   logic [ACC_W-1:0]         round_sum;
   logic [BASE_W-1:0]        base_raw;
   logic [ANGLE_W-1:0]       base_angle;
   logic                     starting;
   logic                     motion_now;
   logic [ANGLE_W-1:0]       peak_start;
   logic [31:0]              good_wide;
   logic [31:0]              bad_wide;

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign pop_ready = (state_ff == ST_IDLE);
   assign pop_fire  = pop_valid && pop_ready;
   assign commit    = (state_ff == ST_UPDATE) && out_free;

   // One vectoring rotation per cycle; arithmetic shifts round toward minus infinity.
   assign step_x  = y_ff >>> iter_ff;
   assign step_y  = x_ff >>> iter_ff;
   assign tab_val = atan_entry(TAB_IDX_W'(iter_ff));
   assign tab_ext = {{(ACC_W - TAB_W){1'b0}}, tab_val};

   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      acc_in = acc_ff;
      if (pop_fire) begin
         x_in   = $signed({{(XY_W - AXIS_W - 8){1'b0}}, pop_entry.mag_z, 8'd0});
         y_in   = $signed({{(XY_W - AXIS_W - 8){1'b0}}, pop_entry.mag_y, 8'd0});
         acc_in = '0;
      end else if (state_ff == ST_ROTATE) begin
         if (!y_ff[XY_W-1]) begin
            x_in   = x_ff + step_x;
            y_in   = y_ff - step_y;
            acc_in = acc_ff + tab_ext;
         end else begin
            x_in   = x_ff - step_x;
            y_in   = y_ff + step_y;
            acc_in = acc_ff - tab_ext;
         end
      end
   end

   // Round the accumulated angle to sixteenths, limit to a right angle, fold by z sign.
   assign acc_pos   = acc_ff[ACC_W-1] ? '0 : acc_ff;
   assign round_sum = acc_pos + ROUND_HALF;
   assign base_raw  = round_sum[ACC_W-1:8];

   always_comb begin
      unique case (kind_ff)
         KIND_ZERO_Y: base_angle = '0;
         KIND_ZERO_Z: base_angle = ANGLE_RIGHT;
         default: begin
            if (base_raw > BASE_W'(ANGLE_RIGHT)) begin
               base_angle = ANGLE_RIGHT;
            end else begin
               base_angle = base_raw[ANGLE_W-1:0];
            end
         end
      endcase
      angle_in = z_neg_ff ? (ANGLE_STRAIGHT - base_angle) : base_angle;
   end

   // Repetition hysteresis: clear, start, peak tracking, end and judgement in one word.
   assign starting   = (angle_ff > thresholds.start_th) && !in_motion_ff;
   assign motion_now = in_motion_ff || starting;
   assign peak_start = starting ? '0 : peak_ff;

   always_comb begin
      in_motion_in = in_motion_ff;
      peak_in      = peak_ff;
      good_in      = good_ff;
      bad_in       = bad_ff;
      event_in     = EVENT_NONE;
      if (kind_ff == KIND_CLEAR) begin
         in_motion_in = 1'b0;
         good_in      = '0;
         bad_in       = '0;
      end else if (motion_now) begin
         in_motion_in = 1'b1;
         peak_in      = (angle_ff > peak_start) ? angle_ff : peak_start;
         if (angle_ff < thresholds.end_th) begin
            in_motion_in = 1'b0;
            if (peak_in >= thresholds.full_th) begin
               event_in = EVENT_GOOD;
               if (good_ff != '1) begin
                  good_in = good_ff + 1'b1;
               end
            end else if (peak_in > thresholds.partial_th) begin
               event_in = EVENT_BAD;
               if (bad_ff != '1) begin
                  bad_in = bad_ff + 1'b1;
               end
            end
         end
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_fire) begin
               priority if (pop_entry.kind == KIND_CLEAR) begin
                  state_in = ST_UPDATE;
               end else if (pop_entry.kind == KIND_ROTATE) begin
                  state_in = ST_ROTATE;
               end else begin
                  state_in = ST_ANGLE;
               end
            end
         end
         ST_ROTATE: begin
            if (iter_ff == ITER_LAST) begin
               state_in = ST_ANGLE;
            end
         end
         ST_ANGLE:  state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         in_motion_ff <= 1'b0;
         peak_ff      <= '0;
         good_ff      <= '0;
         bad_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
            in_motion_ff <= in_motion_in;
            peak_ff      <= peak_in;
            good_ff      <= good_in;
            bad_ff       <= bad_in;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath and result payload.
   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
      if (pop_fire) begin
         kind_ff  <= pop_entry.kind;
         z_neg_ff <= pop_entry.z_neg;
         iter_ff  <= '0;
         angle_ff <= '0;
      end else if (state_ff == ST_ROTATE) begin
         iter_ff <= iter_ff + 1'b1;
      end else if (state_ff == ST_ANGLE) begin
         angle_ff <= angle_in;
      end
      if (commit) begin
         tilt_ff   <= angle_ff;
         active_ff <= in_motion_in;
         event_ff  <= event_in;
      end
   end

   // Totals show the low bits of the counters.
   assign good_wide = 32'(good_ff);
   assign bad_wide  = 32'(bad_ff);

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.tilt_angle = tilt_ff;
   assign rsp_ch.rep_active = active_ff;
   assign rsp_ch.rep_event  = event_ff;
   assign rsp_ch.good_total = good_wide[TOTAL_W-1:0];
   assign rsp_ch.bad_total  = bad_wide[TOTAL_W-1:0];

   // Checks.
   `TRC_ASSERT_IMP(a_event_ends_rep, clock, reset,
      rsp_valid_ff && (event_ff != EVENT_NONE), !active_ff,
      "A counted repetition must leave the block inactive.")
   `TRC_ASSERT_NXT(a_rotate_done, clock, reset,
      (state_ff == ST_ROTATE) && (iter_ff == ITER_LAST), state_ff == ST_ANGLE,
      "The last rotation must be followed by the angle step.")
   `TRC_ASSERT_IMP(a_good_step, clock, reset,
      good_ff != $past(good_ff), (good_ff == $past(good_ff) + 1'b1) || (good_ff == '0),
      "The good counter may only step by one or clear.")

endmodule

`default_nettype wire

FILE: design/tilt_rep_counter_top.sv
// A sample passes from acceptance through the rotation, angle and update states to the
// result register; a zero-axis sample skips the rotations, a clear goes straight to the
// update state and a waiting result holds the back end. The single shared rotation stage
// of the arctangent unit takes no new sample until the last is done; a two-word queue lets
// requests in meanwhile. Synchronous active-high reset restores the threshold defaults,
// clears the counters, the active flag, the peak and the queue; there is no clearing pass.
`default_nettype none

module tilt_rep_counter_top #(
   parameter int ANGLE_ITERATIONS = 16,
   parameter int COUNT_BITS       = 16
) (
   input  logic      clock,
   input  logic      reset,
   trc_req_if.sink   req_ch,
   trc_rsp_if.source rsp_ch,
   trc_csr_if.sink   csr_ch
);
   import trc_pkg::*;

   thresholds_type  thresholds_ff;
   logic            push_valid;
   logic            push_ready;
   queue_entry_type push_entry;
   logic            pop_valid;
   logic            pop_ready;
   queue_entry_type pop_entry;

   // Threshold registers; writes are always taken.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresholds_ff.start_th   <= START_RESET;
         thresholds_ff.end_th     <= END_RESET;
         thresholds_ff.full_th    <= FULL_RESET;
         thresholds_ff.partial_th <= PARTIAL_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_START:   thresholds_ff.start_th   <= csr_ch.data;
            REG_END:     thresholds_ff.end_th     <= csr_ch.data;
            REG_FULL:    thresholds_ff.full_th    <= csr_ch.data;
            REG_PARTIAL: thresholds_ff.partial_th <= csr_ch.data;
            default: ;
         endcase
      end
   end

   trc_front u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   trc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   trc_back #(
      .ANGLE_ITERATIONS (ANGLE_ITERATIONS),
      .COUNT_BITS       (COUNT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .thresholds (thresholds_ff),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire
